// ----- hw/rtl/pattern_removal_filter_assert.svh -----
// Assertion macros used by the checker of the pattern removal filter.
`ifndef PATTERN_REMOVAL_FILTER_ASSERT_SVH
`define PATTERN_REMOVAL_FILTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PRF_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PRF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/prf_pkg.sv -----
// Shared types, constants and helpers of the pattern removal filter.
package prf_pkg;

   // Field and register widths fixed by the interface.
   localparam int CHAR_W     = 8;
   localparam int PAT_LEN_W  = 5;
   localparam int PAT_WORD_W = 64;
   localparam int CSR_IDX_W  = 2;

   // Upper bound of the pattern length; descriptor fields are sized for it.
   localparam int PAT_LIMIT = 16;
   localparam int CNT_W     = $clog2(PAT_LIMIT + 1);
   localparam int IDX_W     = $clog2(PAT_LIMIT);

   // Number of descriptors held between the front and the back.
   localparam int QUEUE_DEPTH = 4;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PATTERN_LEN  = 2'd0,
      CSR_PATTERN_LOW  = 2'd1,
      CSR_PATTERN_HIGH = 2'd2
   } csr_index_type;

   // Control part of one emit descriptor: how many of the oldest window bytes
   // to send, where the oldest one sits, and whether the string ends here.
   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic [IDX_W-1:0] top;
      logic             last;
   } desc_ctl_type;

   // Picks pattern character idx out of the two pattern words.
   function automatic logic [CHAR_W-1:0] pat_byte(input logic [PAT_WORD_W-1:0] lo,
                                                  input logic [PAT_WORD_W-1:0] hi,
                                                  input logic [IDX_W-1:0] idx);
      logic [PAT_WORD_W-1:0] word;
      word = idx[IDX_W-1] ? hi : lo;
      return word[{idx[2:0], 3'b000} +: CHAR_W];
   endfunction

endpackage

// ----- hw/rtl/prf_front.sv -----
// Front end: keeps the character window, matches it and issues emit descriptors.
module prf_front import prf_pkg::*; #(
   parameter int MAX_PATTERN = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                accept,
   input  logic [CHAR_W-1:0]                   in_char,
   input  logic                                in_last,
   input  logic [PAT_LEN_W-1:0]                pattern_len,
   input  logic [PAT_WORD_W-1:0]               pattern_low,
   input  logic [PAT_WORD_W-1:0]               pattern_high,
   output logic                                enq,
   output logic [MAX_PATTERN-1:0][CHAR_W-1:0]  enq_bytes,
   output desc_ctl_type                        enq_ctl
);

   localparam int CW = $clog2(MAX_PATTERN + 1);

   // The window is stored newest first: entry 0 holds the latest character.
   logic [MAX_PATTERN-1:0][CHAR_W-1:0] win_ff, win_in;
   logic [CW-1:0]                      cnt_ff, cnt_in;
   logic [CW-1:0]                      eff_len;
   logic [CW-1:0]                      fill;
   logic [CW-1:0]                      emit_cnt;
   logic [MAX_PATTERN-1:0][CNT_W-1:0]  pos;
   logic [MAX_PATTERN-1:0]             hit;
   logic                               match;

   // Pattern lengths above the window size are clamped to it.
   always_comb begin
      if (pattern_len > PAT_LEN_W'(MAX_PATTERN)) begin
         eff_len = CW'(MAX_PATTERN);
      end else begin
         eff_len = pattern_len[CW-1:0];
      end
   end

   // Shift the new character into the window.
   always_comb begin
      win_in[0] = in_char;
      for (int i = 1; i < MAX_PATTERN; i++) begin
         win_in[i] = win_ff[i-1];
      end
   end

   assign fill = cnt_ff + CW'(1);

   // The newest eff_len characters are compared against the pattern, the
   // newest one against the last pattern character.
   always_comb begin
      for (int i = 0; i < MAX_PATTERN; i++) begin
         pos[i] = CNT_W'(eff_len) - CNT_W'(1) - CNT_W'(i);
         hit[i] = (CNT_W'(i) >= CNT_W'(eff_len)) ||
                  (win_in[i] == pat_byte(pattern_low, pattern_high, pos[i][IDX_W-1:0]));
      end
   end

   assign match = (eff_len != '0) && (fill >= eff_len) && (&hit);

   // Decide how many of the oldest characters leave and how many stay.
   always_comb begin
      if (eff_len == '0) begin
         emit_cnt = fill;
         cnt_in   = '0;
      end else if (fill >= eff_len) begin
         if (match) begin
            emit_cnt = fill - eff_len;
            cnt_in   = '0;
         end else begin
            emit_cnt = fill - eff_len + CW'(1);
            cnt_in   = eff_len - CW'(1);
         end
      end else begin
         emit_cnt = '0;
         cnt_in   = fill;
      end
      // End of string: everything left in the window is flushed.
      if (in_last) begin
         cnt_in = '0;
         if (!match) begin
            emit_cnt = fill;
         end
      end
   end

   // A descriptor is issued when something leaves or the string ends.
   assign enq           = accept && ((emit_cnt != '0) || in_last);
   assign enq_bytes     = win_in;
   assign enq_ctl.count = CNT_W'(emit_cnt);
   assign enq_ctl.top   = IDX_W'(fill - CW'(1));
   assign enq_ctl.last  = in_last;

   // Window fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (accept) begin
         cnt_ff <= cnt_in;
      end
   end

   // Window characters, qualified by the fill count.
   always_ff @(posedge clock) begin
      if (accept) begin
         win_ff <= win_in;
      end
   end

endmodule

// ----- hw/rtl/prf_queue.sv -----
// Small register queue of emit descriptors between the front and the back.
module prf_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [DEPTH-1:0][WIDTH-1:0] slot_ff;
   logic [AW-1:0]               wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]               rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]               cnt_ff, cnt_in;
   logic                        do_wr, do_rd;

   assign full    = (cnt_ff == NW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   // Pointer wrap and occupancy.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + NW'(1);
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Descriptor storage.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- hw/rtl/prf_back.sv -----
// Back end: turns emit descriptors into result beats, one character per cycle unless stalled.
module prf_back import prf_pkg::*; #(
   parameter int MAX_PATTERN = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                head_valid,
   input  logic [MAX_PATTERN-1:0][CHAR_W-1:0]  head_bytes,
   input  desc_ctl_type                        head_ctl,
   output logic                                head_take,
   output logic [CHAR_W-1:0]                   out_char,
   output logic                                out_valid_char,
   output logic                                out_last,
   output logic                                out_empty,
   input  logic                                out_pop
);

   localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

   // Descriptor being worked off.
   logic                               cur_valid_ff;
   logic [MAX_PATTERN-1:0][CHAR_W-1:0] cur_bytes_ff;
   logic [IDX_W-1:0]                   cur_ptr_ff;
   logic [CNT_W-1:0]                   cur_left_ff;
   logic                               cur_last_ff;

   // Output register.
   logic                               out_valid_ff;
   logic [CHAR_W-1:0]                  out_char_ff;
   logic                               out_vchar_ff;
   logic                               out_last_ff;

   logic                               out_free;
   logic                               emit;
   logic                               cur_done;
   logic [CHAR_W-1:0]                  beat_char;
   logic                               beat_vchar;
   logic                               beat_last;

   assign out_free  = !out_valid_ff || out_pop;
   assign emit      = cur_valid_ff && out_free;
   assign cur_done  = (cur_left_ff <= CNT_W'(1));
   assign head_take = head_valid && (!cur_valid_ff || (emit && cur_done));

   // Next beat: the oldest remaining character, or a bare end marker.
   always_comb begin
      if (cur_left_ff == '0) begin
         beat_char  = '0;
         beat_vchar = 1'b0;
         beat_last  = 1'b1;
      end else begin
         beat_char  = cur_bytes_ff[cur_ptr_ff[IW-1:0]];
         beat_vchar = 1'b1;
         beat_last  = cur_last_ff && (cur_left_ff == CNT_W'(1));
      end
   end

   // Working descriptor control.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
      end else if (head_take) begin
         cur_valid_ff <= 1'b1;
      end else if (emit && cur_done) begin
         cur_valid_ff <= 1'b0;
      end
   end

   // Working descriptor payload: load a new one or step to the next character.
   always_ff @(posedge clock) begin
      if (head_take) begin
         cur_bytes_ff <= head_bytes;
         cur_ptr_ff   <= head_ctl.top;
         cur_left_ff  <= head_ctl.count;
         cur_last_ff  <= head_ctl.last;
      end else if (emit && !cur_done) begin
         cur_ptr_ff  <= cur_ptr_ff - IDX_W'(1);
         cur_left_ff <= cur_left_ff - CNT_W'(1);
      end
   end

   // Output register valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit) begin
         out_valid_ff <= 1'b1;
      end else if (out_pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (emit) begin
         out_char_ff  <= beat_char;
         out_vchar_ff <= beat_vchar;
         out_last_ff  <= beat_last;
      end
   end

   assign out_empty      = !out_valid_ff;
   assign out_char       = out_char_ff;
   assign out_valid_char = out_vchar_ff;
   assign out_last       = out_last_ff;

endmodule

// ----- hw/rtl/pattern_removal_filter.sv -----
// Top level of the pattern removal filter: configuration registers and the front/back datapath.
//
// Removes every non-overlapping occurrence of a pattern of up to MAX_PATTERN
// characters from a string that arrives one character per beat, greedy from
// left to right. The block takes one character every cycle while the queue
// is not full; a beat marked last flushes the characters still held, and a
// string that ends with nothing left yields a single bare end beat. Results
// leave at one beat per cycle while they are popped; the first result that a
// character frees passes the queue slot, the working descriptor register and
// the output register before it shows on the result ports. The front end
// classifies each character in its cycle and hands a descriptor to a queue
// of four entries; the back end sends one character of the head descriptor
// per cycle while the output is not stalled, and full rises when the queue
// is full, which happens when end flushes or a stalled result side outpace
// the back end. Configuration writes are always ready and take effect on the
// next cycle; write them only between strings or with the block drained.
module pattern_removal_filter import prf_pkg::*; #(
   parameter int MAX_PATTERN = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // Character input.
   input  logic                  push,
   output logic                  full,
   input  logic [CHAR_W-1:0]     req_in_char,
   input  logic                  req_in_last,
   // Result output.
   output logic                  rsp_empty,
   input  logic                  pop,
   output logic [CHAR_W-1:0]     rsp_out_char,
   output logic                  rsp_out_valid_char,
   output logic                  rsp_out_last,
   // Configuration writes.
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [PAT_WORD_W-1:0] csr_data
);

   localparam int CTL_W = $bits(desc_ctl_type);
   localparam int BYT_W = MAX_PATTERN * CHAR_W;
   localparam int DW    = CTL_W + BYT_W;

   logic [PAT_LEN_W-1:0]               pattern_len_ff;
   logic [PAT_WORD_W-1:0]              pattern_low_ff;
   logic [PAT_WORD_W-1:0]              pattern_high_ff;

   logic                               accept;
   logic                               enq;
   logic [MAX_PATTERN-1:0][CHAR_W-1:0] enq_bytes;
   desc_ctl_type                       enq_ctl;
   logic [DW-1:0]                      q_rd_data;
   logic                               q_empty;
   logic                               head_take;
   logic [MAX_PATTERN-1:0][CHAR_W-1:0] head_bytes;
   desc_ctl_type                       head_ctl;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_len_ff  <= '0;
         pattern_low_ff  <= '0;
         pattern_high_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PATTERN_LEN: begin
               pattern_len_ff <= csr_data[PAT_LEN_W-1:0];
            end
            CSR_PATTERN_LOW: begin
               pattern_low_ff <= csr_data;
            end
            CSR_PATTERN_HIGH: begin
               pattern_high_ff <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // A character beat is taken whenever the descriptor queue has room.
   assign accept = push && !full;

   prf_front #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .in_char      (req_in_char),
      .in_last      (req_in_last),
      .pattern_len  (pattern_len_ff),
      .pattern_low  (pattern_low_ff),
      .pattern_high (pattern_high_ff),
      .enq          (enq),
      .enq_bytes    (enq_bytes),
      .enq_ctl      (enq_ctl)
   );

   prf_queue #(
      .WIDTH (DW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (enq),
      .wr_data ({enq_ctl, enq_bytes}),
      .full    (full),
      .rd_en   (head_take),
      .rd_data (q_rd_data),
      .empty   (q_empty)
   );

   // Split the head descriptor back into its parts.
   assign head_ctl   = desc_ctl_type'(q_rd_data[DW-1 -: CTL_W]);
   assign head_bytes = q_rd_data[BYT_W-1:0];

   prf_back #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (!q_empty),
      .head_bytes     (head_bytes),
      .head_ctl       (head_ctl),
      .head_take      (head_take),
      .out_char       (rsp_out_char),
      .out_valid_char (rsp_out_valid_char),
      .out_last       (rsp_out_last),
      .out_empty      (rsp_empty),
      .out_pop        (pop)
   );

endmodule

// ----- hw/rtl/prf_checker.sv -----
// Port-level checker of the pattern removal filter and its bind.
`include "pattern_removal_filter_assert.svh"

module prf_checker (
   input logic       clock,
   input logic       reset,
   input logic       push,
   input logic       full,
   input logic       pop,
   input logic       rsp_empty,
   input logic [7:0] rsp_out_char,
   input logic       rsp_out_valid_char,
   input logic       rsp_out_last
);

   // A bare end beat always closes its string.
   `PRF_ASSERT_SAME(a_marker_is_last, !rsp_empty && !rsp_out_valid_char, rsp_out_last, "bare end beat without last")

   // The queue only fills up right after a character beat was taken.
   `PRF_ASSERT_SAME(a_full_after_accept, $rose(full), $past(push && !full) || $past(reset), "full rose without an accepted beat")

   // A waiting result only goes away when it is popped.
   `PRF_ASSERT_SAME(a_empty_after_pop, $rose(rsp_empty), $past(pop) || $past(reset), "result dropped without a pop")

   // A stalled result beat holds its payload.
   `PRF_ASSERT_NEXT(a_stall_holds, !rsp_empty && !pop, !rsp_empty && $stable(rsp_out_char) && $stable(rsp_out_valid_char) && $stable(rsp_out_last), "stalled result beat changed")

endmodule

bind pattern_removal_filter prf_checker u_prf_checker (.*);

// ----- test/tb_pattern_removal_filter.sv -----
// Testbench of the pattern removal filter: directed and random strings checked against a predictor.
module tb_pattern_removal_filter import prf_pkg::*;;

   localparam int MAX_PAT       = PAT_LIMIT;
   localparam int LIMIT_CYCLES  = 400000;
   localparam int SETTLE_CYCLES = 16;
   localparam int MAX_REPORTS   = 10;
   localparam int SEGMENT_CHARS = 20;
   localparam int MAX_STRING    = 40;

   typedef logic [CHAR_W-1:0] char_q_type[$];

   // One result beat as the filter should present it.
   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              has_char;
      logic              last;
   } out_beat_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   logic [CHAR_W-1:0]     req_in_char = '0;
   logic                  req_in_last = 1'b0;
   logic                  rsp_empty;
   logic                  pop = 1'b0;
   logic [CHAR_W-1:0]     rsp_out_char;
   logic                  rsp_out_valid_char;
   logic                  rsp_out_last;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_PATTERN_LEN;
   logic [PAT_WORD_W-1:0] csr_data = '0;

   // Predictor copy of the configuration and of the match window.
   logic [PAT_LEN_W-1:0]  pat_len = '0;
   logic [PAT_WORD_W-1:0] pat_lo = '0;
   logic [PAT_WORD_W-1:0] pat_hi = '0;
   logic [CHAR_W-1:0]     win [MAX_PAT];
   int                    win_fill = 0;

   out_beat_type          out_beat_q[$];
   out_beat_type          head_beat;
   logic [CHAR_W-1:0]     alpha_base = '0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int errors = 0;
   int beats_checked = 0;
   int chars_sent = 0;
   int strings_sent = 0;
   int cycle_count = 0;

   pattern_removal_filter #(
      .MAX_PATTERN(MAX_PAT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .push(push),
      .full(full),
      .req_in_char(req_in_char),
      .req_in_last(req_in_last),
      .rsp_empty(rsp_empty),
      .pop(pop),
      .rsp_out_char(rsp_out_char),
      .rsp_out_valid_char(rsp_out_valid_char),
      .rsp_out_last(rsp_out_last),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Run limit in case the filter hangs or a result never shows up.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d beats still pending",
                  cycle_count, out_beat_q.size());
         $display("FAILED: results differ");
         $finish;
      end
   end

   // The result side stalls at random according to the current phase.
   always @(negedge clock) begin
      pop <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Compare every accepted result beat with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && pop && !rsp_empty) begin
         beats_checked++;
         if (out_beat_q.size() == 0) begin
            if (errors < MAX_REPORTS)
               $display("Unexpected beat: char %h valid %b last %b",
                        rsp_out_char, rsp_out_valid_char, rsp_out_last);
            errors++;
         end else begin
            head_beat = out_beat_q.pop_front();
            if (rsp_out_char !== head_beat.ch || rsp_out_valid_char !== head_beat.has_char ||
                rsp_out_last !== head_beat.last) begin
               if (errors < MAX_REPORTS)
                  $display("Mismatch: expected char %h valid %b last %b, got %h %b %b",
                           head_beat.ch, head_beat.has_char, head_beat.last,
                           rsp_out_char, rsp_out_valid_char, rsp_out_last);
               errors++;
            end
         end
      end
   end

   // Pattern length in use; values above the limit saturate.
   function automatic int eff_len();
      return (pat_len > PAT_LEN_W'(MAX_PAT)) ? MAX_PAT : int'(pat_len);
   endfunction

   function automatic logic [CHAR_W-1:0] pat_char(input int i);
      return (i < 8) ? pat_lo[8*i +: CHAR_W] : pat_hi[8*(i-8) +: CHAR_W];
   endfunction

   // Removes the oldest character from the window and returns it.
   function automatic logic [CHAR_W-1:0] take_oldest();
      logic [CHAR_W-1:0] c;
      c = win[0];
      for (int i = 1; i < win_fill; i++)
         win[i-1] = win[i];
      if (win_fill > 0)
         win_fill--;
      return c;
   endfunction

   // Works out the result beats that one accepted character frees.
   task automatic filter_char(input logic [CHAR_W-1:0] c, input logic last);
      int           len;
      int           n;
      logic         hit;
      out_beat_type tail;
      len = eff_len();
      n = 0;
      if (win_fill > MAX_PAT - 1)
         win_fill = MAX_PAT - 1;
      win[win_fill] = c;
      win_fill++;
      // A window longer than the pattern releases its oldest characters.
      while (win_fill > len) begin
         out_beat_q.push_back('{take_oldest(), 1'b1, 1'b0});
         n++;
      end
      // A full window is either dropped as a match or gives up one character.
      if (len > 0 && win_fill == len) begin
         hit = 1'b1;
         for (int i = 0; i < len; i++)
            if (win[i] != pat_char(i))
               hit = 1'b0;
         if (hit) begin
            win_fill = 0;
         end else begin
            out_beat_q.push_back('{take_oldest(), 1'b1, 1'b0});
            n++;
         end
      end
      // The end of the string flushes the window and marks the final beat.
      if (last) begin
         while (win_fill > 0) begin
            out_beat_q.push_back('{take_oldest(), 1'b1, 1'b0});
            n++;
         end
         if (n == 0) begin
            out_beat_q.push_back('{CHAR_W'(0), 1'b0, 1'b1});
         end else begin
            tail = out_beat_q.pop_back();
            tail.last = 1'b1;
            out_beat_q.push_back(tail);
         end
      end
   endtask

   // Sends one character beat, with random idle cycles ahead of it.
   task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         push = 1'b0;
         @(negedge clock);
      end
      push = 1'b1;
      req_in_char = c;
      req_in_last = last;
      do @(posedge clock); while (full);
      filter_char(c, last);
      chars_sent++;
      if (last)
         strings_sent++;
   endtask

   task automatic send_string(input char_q_type chars);
      foreach (chars[i])
         send_char(chars[i], i == chars.size() - 1);
   endtask

   // Stops sending and waits until all predicted beats have come out.
   task automatic wait_idle();
      @(negedge clock);
      push = 1'b0;
      while (out_beat_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [PAT_WORD_W-1:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PATTERN_LEN:  pat_len = value[PAT_LEN_W-1:0];
         CSR_PATTERN_LOW:  pat_lo = value;
         CSR_PATTERN_HIGH: pat_hi = value;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Pattern length zero after reset: strings pass through unchanged.
   task automatic test_passthrough();
      char_q_type s;
      s = '{8'h00, 8'hFF};
      send_string(s);
      s = '{8'h5A};
      send_string(s);
   endtask

   // Pattern "abc": removal without overlap, whole-string match, short string.
   task automatic test_basic_removal();
      char_q_type s;
      wait_idle();
      write_csr(CSR_PATTERN_LEN, 64'd3);
      write_csr(CSR_PATTERN_LOW, 64'h0000_0000_0063_6261);
      s = '{8'h61, 8'h61, 8'h62, 8'h63, 8'h62, 8'h63};
      send_string(s);
      s = '{8'h61, 8'h62, 8'h63};
      send_string(s);
      s = '{8'h61, 8'h62};
      send_string(s);
   endtask

   // Oversized length field, then a shorter zero-byte pattern in mid string.
   task automatic test_length_change_midstring();
      char_q_type s;
      wait_idle();
      write_csr(CSR_PATTERN_LEN, '1);
      write_csr(CSR_PATTERN_LOW, '1);
      write_csr(CSR_PATTERN_HIGH, '1);
      repeat (5) send_char(8'hFF, 1'b0);
      wait_idle();
      write_csr(CSR_PATTERN_LEN, 64'd2);
      write_csr(CSR_PATTERN_LOW, 64'd0);
      s = '{8'h00, 8'h00, 8'h7F};
      send_string(s);
   endtask

   // Random patterns and strings built mostly from pattern pieces.
   task automatic test_random_streams(input int send_pct, input int stall_pct);
      char_q_type            s;
      int                    seg_sent;
      int                    sel;
      int                    plen;
      int                    cut;
      logic [PAT_LEN_W-1:0]  new_len;
      logic [PAT_WORD_W-1:0] lo;
      logic [PAT_WORD_W-1:0] hi;
      logic [PAT_WORD_W-1:0] len_word;
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      repeat (3) begin
         wait_idle();
         // Pick a length, mostly short so that matches are frequent.
         sel = $urandom_range(9);
         if (sel == 0)
            new_len = '0;
         else if (sel == 1)
            new_len = PAT_LEN_W'(MAX_PAT);
         else if (sel == 2)
            new_len = PAT_LEN_W'($urandom_range(31, MAX_PAT + 1));
         else
            new_len = PAT_LEN_W'($urandom_range(5, 1));
         // Pattern characters come from a three-letter alphabet most of the time.
         alpha_base = CHAR_W'($urandom_range(255));
         if ($urandom_range(7) == 0) begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
         end else begin
            for (int i = 0; i < 8; i++) begin
               lo[8*i +: CHAR_W] = alpha_base + CHAR_W'($urandom_range(2));
               hi[8*i +: CHAR_W] = alpha_base + CHAR_W'($urandom_range(2));
            end
         end
         len_word = {$urandom, $urandom};
         len_word[PAT_LEN_W-1:0] = new_len;
         write_csr(CSR_PATTERN_LEN, len_word);
         write_csr(CSR_PATTERN_LOW, lo);
         write_csr(CSR_PATTERN_HIGH, hi);
         seg_sent = 0;
         while (seg_sent < SEGMENT_CHARS) begin
            s.delete();
            plen = eff_len();
            repeat ($urandom_range(6, 1)) begin
               sel = $urandom_range(9);
               if (sel < 4 && plen > 0) begin
                  for (int i = 0; i < plen; i++)
                     s.push_back(pat_char(i));
               end else if (sel < 6 && plen > 1) begin
                  cut = $urandom_range(plen - 1, 1);
                  for (int i = 0; i < cut; i++)
                     s.push_back(pat_char(i));
               end else if (sel < 9) begin
                  repeat ($urandom_range(3, 1))
                     s.push_back(alpha_base + CHAR_W'($urandom_range(2)));
               end else begin
                  s.push_back(CHAR_W'($urandom));
               end
            end
            while (s.size() > MAX_STRING)
               void'(s.pop_back());
            send_string(s);
            seg_sent += s.size();
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_passthrough();
      test_basic_removal();
      test_length_change_midstring();
      test_random_streams(0, 0);
      test_random_streams(64, 0);
      test_random_streams(0, 64);
      test_random_streams(27, 27);
      wait_idle();
      $display("Sent %0d characters in %0d strings under four idling mixes,", chars_sent,
               strings_sent);
      $display("checked %0d result beats, %0d errors.", beats_checked, errors);
      if (errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
